// ===== rtl/core/vertex_dedup_index_table_assert.svh =====
// Assertion macros used by the vertex table RTL.
`ifndef VERTEX_DEDUP_INDEX_TABLE_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// A condition that implies another in the same cycle.
`define VDIT_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// A condition that implies another in the next cycle.
`define VDIT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define VDIT_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define VDIT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ===== rtl/core/vdit_pkg.sv =====
// Shared constants and types of the vertex table.
package vdit_pkg;

  // Default sizes of the vertex store.
  localparam int VERTEX_DEPTH_DEF = 256;
  localparam int COORD_WIDTH_DEF  = 32;

  // Fixed widths of the external fields.
  localparam int POS_W       = 32;
  localparam int OUT_INDEX_W = 8;
  localparam int OUT_TOTAL_W = 9;
  localparam int POLY_W      = 16;

  typedef logic [1:0] status_t;

  // Result status codes.
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_FULL    = 2'd1;
  localparam status_t STATUS_CLEARED = 2'd2;

  // Request codes.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

endpackage

// ===== rtl/core/vdit_cell.sv =====
// One cell of the vertex row: holds one stored vertex and checks the passing search token.
module vdit_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int COORD_WIDTH = 32,
  parameter int IDX_W       = 8,
  parameter int USED_W      = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tok_vld_in,
  input  logic                   tok_found_in,
  input  logic [IDX_W-1:0]       tok_idx_in,
  input  logic [COORD_WIDTH-1:0] qx,
  input  logic [COORD_WIDTH-1:0] qy,
  input  logic [COORD_WIDTH-1:0] qz,
  input  logic [USED_W-1:0]      used,
  input  logic                   wr_en,
  output logic                   tok_vld_out,
  output logic                   tok_found_out,
  output logic [IDX_W-1:0]       tok_idx_out
);

  logic [COORD_WIDTH-1:0] ex;
  logic [COORD_WIDTH-1:0] ey;
  logic [COORD_WIDTH-1:0] ez;
  logic                   occupied;
  logic                   hit;
  logic                   wr_sel;

  // The cell holds a valid vertex only when its slot lies below the fill count.
  assign occupied = USED_W'(CELL_INDEX) < used;
  assign hit      = tok_vld_in && !tok_found_in && occupied &&
                    (ex == qx) && (ey == qy) && (ez == qz);
  assign wr_sel   = wr_en && (used == USED_W'(CELL_INDEX));

  // The stored vertex is written when the cell is the next free slot.
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      ex <= qx;
      ey <= qy;
      ez <= qz;
    end
  end

  // The token moves one cell further each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_vld_out <= 1'b0;
    end else begin
      tok_vld_out <= tok_vld_in;
    end
  end

  // An earlier hit is kept, so the lowest matching slot wins.
  always_ff @(posedge clk) begin
    tok_found_out <= tok_found_in || hit;
    tok_idx_out   <= tok_found_in ? tok_idx_in : IDX_W'(CELL_INDEX);
  end

endmodule

// ===== rtl/core/vertex_dedup_index_table.sv =====
// Top level of the vertex table: controller, fill count, polygon count and the cell row.
//
// Welds a stream of polygon corners into an indexed vertex table by exact match. An add
// request sends a search token down a row of VERTEX_DEPTH cells, one cell per cycle; each
// cell holds one stored vertex and marks the token with its slot on the first match. An
// add result passes through the start register, the cell row and the search result register
// and then into the output register; the next input is taken once it has moved there. A clear
// request, or a corner of a polygon that has already failed, goes straight into the output
// register at its transfer. One item is worked on at a time. When the table is full, an
// unmatched corner is dropped with status 1 and the rest of its polygon is dropped too; that
// polygon is not counted. Stored vertices need no clearing: only slots below the fill count
// are ever compared.
`include "vertex_dedup_index_table_assert.svh"

module vertex_dedup_index_table
  import vdit_pkg::*;
#(
  parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic signed [POS_W-1:0]       pos_x,
  input  logic signed [POS_W-1:0]       pos_y,
  input  logic signed [POS_W-1:0]       pos_z,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [OUT_INDEX_W-1:0]        vertex_index,
  output logic                          is_new,
  output status_t                       status,
  output logic [POLY_W-1:0]             poly_index,
  output logic [OUT_TOTAL_W-1:0]        vertex_total
);

  localparam int IDX_W  = $clog2(VERTEX_DEPTH);
  localparam int USED_W = $clog2(VERTEX_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]             state;
  logic [USED_W-1:0]      used;
  logic [POLY_W-1:0]      poly_counter;
  logic                   poly_failed;
  logic                   start;
  logic [COORD_WIDTH-1:0] q_x;
  logic [COORD_WIDTH-1:0] q_y;
  logic [COORD_WIDTH-1:0] q_z;
  logic                   q_last;
  logic                   found_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   out_free;
  logic                   in_xfer;
  logic                   table_full;
  logic                   wr_en;
  logic                   res_load;

  logic                   tok_vld   [0:VERTEX_DEPTH];
  logic                   tok_found [0:VERTEX_DEPTH];
  logic [IDX_W-1:0]       tok_idx   [0:VERTEX_DEPTH];

  // Handshake and write control.
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == S_IDLE) && out_free);
  assign in_xfer    = in_valid && !in_stall;
  assign table_full = (used == USED_W'(VERTEX_DEPTH));
  assign wr_en      = (state == S_DONE) && out_free && !found_r && !table_full;

  // A result is loaded right away for a clear or a dropped corner, else after the search.
  assign res_load = ((state == S_IDLE) && in_xfer &&
                     ((req_type == REQ_CLEAR) || poly_failed)) ||
                    ((state == S_DONE) && out_free);

  // The search token enters the head of the row with no match yet.
  assign tok_vld[0]   = start;
  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;

  // Row of vertex cells.
  for (genvar k = 0; k < VERTEX_DEPTH; k++) begin : g_cell
    vdit_cell #(
      .CELL_INDEX  (k),
      .COORD_WIDTH (COORD_WIDTH),
      .IDX_W       (IDX_W),
      .USED_W      (USED_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .tok_vld_in    (tok_vld[k]),
      .tok_found_in  (tok_found[k]),
      .tok_idx_in    (tok_idx[k]),
      .qx            (q_x),
      .qy            (q_y),
      .qz            (q_z),
      .used          (used),
      .wr_en         (wr_en),
      .tok_vld_out   (tok_vld[k+1]),
      .tok_found_out (tok_found[k+1]),
      .tok_idx_out   (tok_idx[k+1])
    );
  end

  // Query and search result registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_x    <= COORD_WIDTH'(pos_x);
      q_y    <= COORD_WIDTH'(pos_y);
      q_z    <= COORD_WIDTH'(pos_z);
      q_last <= last_point;
    end
    if (tok_vld[VERTEX_DEPTH]) begin
      found_r <= tok_found[VERTEX_DEPTH];
      idx_r   <= tok_idx[VERTEX_DEPTH];
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vertex_index <= '0;
      is_new       <= 1'b0;
      if (req_type == REQ_CLEAR) begin
        status       <= STATUS_CLEARED;
        poly_index   <= '0;
        vertex_total <= '0;
      end else begin
        status       <= STATUS_FULL;
        poly_index   <= poly_counter;
        vertex_total <= OUT_TOTAL_W'(used);
      end
    end else if ((state == S_DONE) && out_free) begin
      poly_index <= poly_counter;
      if (found_r) begin
        vertex_index <= OUT_INDEX_W'(idx_r);
        is_new       <= 1'b0;
        status       <= STATUS_OK;
        vertex_total <= OUT_TOTAL_W'(used);
      end else if (!table_full) begin
        vertex_index <= OUT_INDEX_W'(used);
        is_new       <= 1'b1;
        status       <= STATUS_OK;
        vertex_total <= OUT_TOTAL_W'(used + USED_W'(1));
      end else begin
        vertex_index <= '0;
        is_new       <= 1'b0;
        status       <= STATUS_FULL;
        vertex_total <= OUT_TOTAL_W'(used);
      end
    end
  end

  // Control state: sequencer, counts and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used         <= '0;
      poly_counter <= '0;
      poly_failed  <= 1'b0;
      start        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      start <= in_xfer && (req_type == REQ_ADD) && !poly_failed;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (req_type == REQ_CLEAR) begin
              used         <= '0;
              poly_counter <= '0;
              poly_failed  <= 1'b0;
            end else if (poly_failed) begin
              // A corner of a failed polygon is dropped without a search.
              if (last_point) begin
                poly_failed <= 1'b0;
              end
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (tok_vld[VERTEX_DEPTH]) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            if (found_r || !table_full) begin
              if (!found_r) begin
                used <= used + USED_W'(1);
              end
              if (q_last) begin
                poly_counter <= poly_counter + POLY_W'(1);
              end
            end else begin
              // Table full: the polygon fails unless this corner closes it.
              poly_failed <= !q_last;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the controller and the cell row.
  `VDIT_ASSERT_IMPLY(a_used_bound, clk, rst, 1'b1, used <= USED_W'(VERTEX_DEPTH))
  `VDIT_ASSERT_IMPLY(a_new_is_ok, clk, rst, out_valid && is_new, status == STATUS_OK)
  `VDIT_ASSERT_NEXT(a_xfer_progress, clk, rst, in_xfer, out_valid || (state == S_SEARCH))
  `VDIT_ASSERT_IMPLY(a_token_in_search, clk, rst, tok_vld[VERTEX_DEPTH], state == S_SEARCH)

endmodule

// ===== bench/vertex_dedup_index_table_tb.sv =====
// Self-checking testbench for the exact-match vertex welding table.
module vertex_dedup_index_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vdit_pkg::*;

  localparam int TBL_DEPTH   = VERTEX_DEPTH_DEF;
  localparam int ITEM_TARGET = 1550;
  localparam logic [POS_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [POS_W-1:0] COORD_MAX = 32'h7FFF_FFFF;

  // Expected outcome of one corner or clear transfer.
  typedef struct packed {
    logic [OUT_INDEX_W-1:0] vertex_index;
    logic                   is_new;
    status_t                status;
    logic [POLY_W-1:0]      poly_index;
    logic [OUT_TOTAL_W-1:0] vertex_total;
  } weld_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   req_type = REQ_ADD;
  logic [POS_W-1:0]       pos_x = '0;
  logic [POS_W-1:0]       pos_y = '0;
  logic [POS_W-1:0]       pos_z = '0;
  logic                   last_point = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [OUT_INDEX_W-1:0] vertex_index;
  logic                   is_new;
  status_t                status;
  logic [POLY_W-1:0]      poly_index;
  logic [OUT_TOTAL_W-1:0] vertex_total;

  // Shadow copy of the vertex table and polygon bookkeeping.
  logic [POS_W-1:0]  tbl_x [TBL_DEPTH];
  logic [POS_W-1:0]  tbl_y [TBL_DEPTH];
  logic [POS_W-1:0]  tbl_z [TBL_DEPTH];
  int                tbl_used = 0;
  logic [POLY_W-1:0] poly_count = '0;
  bit                poly_dropped = 1'b0;

  weld_result_t pending_welds[$];

  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  int n_new = 0;
  int n_match = 0;
  int n_drop = 0;
  int n_clear = 0;

  vertex_dedup_index_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .is_new       (is_new),
    .status       (status),
    .poly_index   (poly_index),
    .vertex_total (vertex_total)
  );

  // Free-running 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Welds one transfer into the shadow table and returns the result it must produce.
  function automatic weld_result_t weld_corner(logic rq, logic [POS_W-1:0] x,
                                               logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                                               logic lp);
    weld_result_t r;
    bit hit;
    int k;
    r = '0;
    hit = 1'b0;
    if (rq == REQ_CLEAR) begin
      tbl_used = 0;
      poly_count = '0;
      poly_dropped = 1'b0;
      r.status = STATUS_CLEARED;
      n_clear++;
      return r;
    end
    r.poly_index = poly_count;
    r.status = STATUS_OK;
    if (poly_dropped) begin
      r.status = STATUS_FULL;
    end else begin
      // Lowest stored vertex that matches on all three coordinates wins.
      for (k = 0; k < tbl_used && !hit; k++) begin
        if (tbl_x[k] == x && tbl_y[k] == y && tbl_z[k] == z) begin
          r.vertex_index = k[OUT_INDEX_W-1:0];
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (tbl_used < TBL_DEPTH) begin
          r.vertex_index = tbl_used[OUT_INDEX_W-1:0];
          tbl_x[tbl_used] = x;
          tbl_y[tbl_used] = y;
          tbl_z[tbl_used] = z;
          tbl_used++;
          r.is_new = 1'b1;
        end else begin
          r.status = STATUS_FULL;
          poly_dropped = 1'b1;
        end
      end
    end
    if (r.status == STATUS_FULL) n_drop++;
    else if (r.is_new) n_new++;
    else n_match++;
    r.vertex_total = tbl_used[OUT_TOTAL_W-1:0];
    // Closing corner: count the polygon only if none of its corners was dropped.
    if (lp) begin
      if (!poly_dropped) poly_count = poly_count + 1'b1;
      poly_dropped = 1'b0;
    end
    return r;
  endfunction

  // Sends one transfer in bursts with random gaps and records its expected result.
  task automatic send_corner(input logic rq, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                             input logic lp);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    pos_x      <= x;
    pos_y      <= y;
    pos_z      <= z;
    last_point <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_welds.push_back(weld_corner(rq, x, y, z, lp));
    items_sent++;
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Coordinate with a bias toward the extremes and small values.
  function automatic logic [POS_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '1;
      3: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // Extremes of the coordinates, matching, and a clear inside a polygon.
  task automatic test_directed_corners();
    send_corner(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 1'b1);
    send_corner(REQ_ADD, '0, '0, '0, 1'b0);
    send_corner(REQ_ADD, '1, '1, '1, 1'b0);
    send_corner(REQ_ADD, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_corner(REQ_ADD, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_corner(REQ_ADD, '0, '0, '0, 1'b0);
    send_corner(REQ_ADD, '0, '0, 32'd1, 1'b0);
    send_corner(REQ_ADD, '0, 32'd1, '0, 1'b0);
    send_corner(REQ_ADD, 32'd1, '0, '0, 1'b1);
    send_corner(REQ_ADD, COORD_MAX, COORD_MIN, '1, 1'b0);
    send_corner(REQ_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_corner(REQ_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_corner(REQ_ADD, '1, '1, '1, 1'b1);
    send_corner(REQ_ADD, 32'd7, 32'd7, 32'd7, 1'b0);
    send_corner(REQ_CLEAR, COORD_MIN, COORD_MAX, '1, 1'b0);
    send_corner(REQ_ADD, 32'd7, 32'd7, 32'd7, 1'b1);
    send_corner(REQ_ADD, 32'd7, 32'd7, 32'd7, 1'b1);
    send_corner(REQ_CLEAR, '0, '0, '0, 1'b0);
  endtask

  // Fills the table, then drives polygons that overflow it.
  task automatic test_table_full();
    int n;
    int k;
    send_corner(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 1'b0);
    while (tbl_used < TBL_DEPTH - 2) begin
      n = $urandom_range(1, 4);
      if (n > TBL_DEPTH - 2 - tbl_used) n = TBL_DEPTH - 2 - tbl_used;
      for (k = 0; k < n; k++)
        send_corner(REQ_ADD, $urandom(), $urandom(), $urandom(), k == n - 1);
    end
    // Two corners take the last slots, the third overflows and the rest are dropped.
    send_corner(REQ_ADD, $urandom(), $urandom(), $urandom(), 1'b0);
    send_corner(REQ_ADD, $urandom(), $urandom(), $urandom(), 1'b0);
    send_corner(REQ_ADD, $urandom(), $urandom(), $urandom(), 1'b0);
    send_corner(REQ_ADD, tbl_x[0], tbl_y[0], tbl_z[0], 1'b0);
    send_corner(REQ_ADD, tbl_x[5], tbl_y[5], tbl_z[5], 1'b1);
    // A full table still welds corners that match.
    k = $urandom_range(0, TBL_DEPTH - 1);
    send_corner(REQ_ADD, tbl_x[k], tbl_y[k], tbl_z[k], 1'b0);
    send_corner(REQ_ADD, tbl_x[TBL_DEPTH-1], tbl_y[TBL_DEPTH-1], tbl_z[TBL_DEPTH-1], 1'b1);
    // Overflow on a single closing corner, and on the closing corner after a match.
    send_corner(REQ_ADD, $urandom(), $urandom(), $urandom(), 1'b1);
    send_corner(REQ_ADD, tbl_x[1], tbl_y[1], tbl_z[1], 1'b0);
    send_corner(REQ_ADD, $urandom(), $urandom(), $urandom(), 1'b1);
    send_corner(REQ_ADD, tbl_x[TBL_DEPTH-1], tbl_y[TBL_DEPTH-1], tbl_z[TBL_DEPTH-1], 1'b1);
    send_corner(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 1'b1);
  endtask

  // Random polygons that mix reused, near-miss and fresh corners with occasional clears.
  task automatic test_random_polygons();
    int corners;
    int k;
    int pick;
    int slot;
    int bitpos;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    x = '0;
    y = '0;
    z = '0;
    while (items_sent < ITEM_TARGET) begin
      // Clear mostly once the table has filled, so that it refills several times.
      if ($urandom_range(0, 99) < ((tbl_used == TBL_DEPTH) ? 12 : 1))
        send_corner(REQ_CLEAR, $urandom(), $urandom(), $urandom(),
                    1'($urandom_range(0, 1)));
      corners = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
      for (k = 0; k < corners; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45 && tbl_used > 0) begin
          slot = $urandom_range(0, tbl_used - 1);
          x = tbl_x[slot];
          y = tbl_y[slot];
          z = tbl_z[slot];
        end else if (pick < 55 && tbl_used > 0) begin
          // Near miss: one bit of one coordinate differs from a stored vertex.
          slot = $urandom_range(0, tbl_used - 1);
          bitpos = $urandom_range(0, POS_W - 1);
          x = tbl_x[slot];
          y = tbl_y[slot];
          z = tbl_z[slot];
          case ($urandom_range(0, 2))
            0: x = x ^ (32'd1 << bitpos);
            1: y = y ^ (32'd1 << bitpos);
            default: z = z ^ (32'd1 << bitpos);
          endcase
        end else if (pick < 60 && k > 0) begin
          // Repeat the previous corner unchanged.
        end else begin
          if (pick < 63)
            send_corner(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 1'b0);
          x = pick_coord();
          y = pick_coord();
          z = pick_coord();
        end
        send_corner(REQ_ADD, x, y, z, k == corners - 1);
      end
    end
  endtask

  // Receiver stalls in segments of random length.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 8);
      end else begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(1, 60);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Compares one field of a result with its expected value.
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Mismatch in result %0d, %s: expected %0h, got %0h",
                 results_checked, field, want, got);
    end
  endtask

  // Checks every result transfer against the oldest expectation.
  always @(posedge clk) begin
    weld_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_welds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result transfer with no corner pending: index %0h status %0h",
                   vertex_index, status);
      end else begin
        want = pending_welds.pop_front();
        check_field("vertex_index", 32'(want.vertex_index), 32'(vertex_index));
        check_field("is_new", 32'(want.is_new), 32'(is_new));
        check_field("status", 32'(want.status), 32'(status));
        check_field("poly_index", 32'(want.poly_index), 32'(poly_index));
        check_field("vertex_total", 32'(want.vertex_total), 32'(vertex_total));
        results_checked++;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_table_full();
    test_random_polygons();
    in_valid <= 1'b0;
    while (pending_welds.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 20) @(posedge clk);
    $display("Sent %0d transfers: %0d new vertices, %0d welded matches, %0d dropped, %0d clears.",
             items_sent, n_new, n_match, n_drop, n_clear);
    $display("Checked %0d results with %0d mismatching fields.", results_checked,
             mismatch_count);
    if (mismatch_count == 0 && pending_welds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vdit_pkg.sv
rtl/core/vdit_cell.sv
rtl/core/vertex_dedup_index_table.sv
bench/vertex_dedup_index_table_tb.sv
